FILE: rtl/fm_va_pkg.sv
// Package for the FM voice allocator: transfer types, slot record type,
// register constants and the note to frequency lookup functions.
// No dependencies.
`default_nettype none

package fm_va_pkg;

  localparam int unsigned NumVoices = 18;
  localparam int unsigned IdxW      = $clog2(NumVoices);
  localparam int unsigned NoteW     = 7;
  localparam int unsigned KoffW     = 5;
  localparam int unsigned CfgW      = 5;
  localparam int unsigned AddrW     = 8;
  localparam int unsigned DataW     = 8;

  localparam logic [CfgW-1:0]  MaxVoicesRst = 5'd18;
  localparam logic [AddrW-1:0] AddrFnumLo   = 8'hA0;
  localparam logic [AddrW-1:0] AddrKeyBlk   = 8'hB0;
  localparam logic [DataW-1:0] KeyOnBit     = 8'h20;

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_ALL_OFF  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [NoteW-1:0] note;
  } in_t;

  typedef struct packed {
    logic             part;
    logic [AddrW-1:0] reg_addr;
    logic [DataW-1:0] reg_data;
    logic             last;
  } out_t;

  typedef struct packed {
    logic [NoteW-1:0] note;
    logic [KoffW-1:0] koff;
  } slot_t;

  // Quotient of a 7-bit note by twelve, by reciprocal multiply (exact for 0..127).
  function automatic logic [3:0] note_div12(input logic [NoteW-1:0] note);
    logic [14:0] prod;
    prod = 15'(note) * 15'd171;
    return 4'(prod >> 11);
  endfunction

  function automatic logic [DataW-1:0] fnum_lo(input logic [3:0] pc);
    logic [DataW-1:0] v;
    case (pc)
      4'd0:    v = 8'h59;
      4'd1:    v = 8'h6D;
      4'd2:    v = 8'h83;
      4'd3:    v = 8'h9A;
      4'd4:    v = 8'hB3;
      4'd5:    v = 8'hCC;
      4'd6:    v = 8'hE8;
      4'd7:    v = 8'h05;
      4'd8:    v = 8'h23;
      4'd9:    v = 8'h44;
      4'd10:   v = 8'h66;
      4'd11:   v = 8'h88;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] fnum_hi(input logic [3:0] pc);
    logic [1:0] v;
    case (pc) inside
      [4'd0:4'd6]:  v = 2'd1;
      [4'd7:4'd11]: v = 2'd2;
      default:      v = 2'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fm_va_cell.sv
// One voice slot cell of the allocator ring: holds a note and its 5-bit key-off value.
// Depends on fm_va_pkg.
`default_nettype none

module fm_va_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire fm_va_pkg::slot_t slot_i,
  output fm_va_pkg::slot_t     slot_o
);
  import fm_va_pkg::*;

  slot_t slot_q;

  // The ring moves one place toward cell zero whenever the sequencer steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (shift_i) begin
      slot_q <= slot_i;
    end
  end

  assign slot_o = slot_q;

endmodule

`default_nettype wire

FILE: rtl/fm_va_ctrl.sv
// Scan sequencer of the allocator: looks at the slot at the head of the cell
// ring, rewrites it, and produces the chip register writes. Depends on fm_va_pkg.
`default_nettype none

module fm_va_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [fm_va_pkg::CfgW-1:0] max_voices_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire fm_va_pkg::in_t         in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output fm_va_pkg::out_t             out_data_o,
  input  wire fm_va_pkg::slot_t       head_i,
  output fm_va_pkg::slot_t            head_o,
  output logic                        shift_o
);
  import fm_va_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [1:0]       op_q, op_d;
  logic [NoteW-1:0] note_q, note_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             found_q, found_d;
  logic             pend_vld_q, pend_vld_d;
  out_t             pend_q, pend_d;
  logic             out_vld_q, out_vld_d;
  out_t             out_q, out_d;

  logic             out_free;
  logic [CfgW-1:0]  used, half, idx_w, chan;
  logic             in_used, part;
  logic             hit_on, hit_off, hit_all;
  logic [3:0]       blk_full, pc;
  logic [KoffW-1:0] koff_new;

  assign out_free = !out_vld_q || !out_stall_i;

  assign used  = (max_voices_i > CfgW'(NumVoices)) ? CfgW'(NumVoices) : max_voices_i;
  assign half  = (op_q == OP_ALL_OFF) ? CfgW'(NumVoices / 2) : (used >> 1);
  assign idx_w = CfgW'(idx_q);
  assign in_used = idx_w < used;
  assign part  = idx_w >= half;
  assign chan  = part ? (idx_w - half) : idx_w;

  assign blk_full = note_div12(note_q);
  assign pc       = 4'(note_q - 7'(blk_full) * 7'd12);
  assign koff_new = {blk_full[2:0], fnum_hi(pc)};

  assign hit_on  = (op_q == OP_NOTE_ON) && in_used && !found_q &&
                   ((head_i.note == '0) || (head_i.note == note_q));
  assign hit_off = (op_q == OP_NOTE_OFF) && in_used && (head_i.note == note_q);
  assign hit_all = (op_q == OP_ALL_OFF);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    note_d     = note_q;
    idx_d      = idx_q;
    found_d    = found_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_d      = out_q;
    head_o     = head_i;
    shift_o    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_data_i.operation;
          note_d  = in_data_i.note;
          idx_d   = '0;
          found_d = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          shift_o = 1'b1;
          idx_d   = idx_q + 1'b1;
          if (hit_on) begin
            // The pending slot is always empty here: earlier slots made no write.
            head_o.note = note_q;
            head_o.koff = koff_new;
            found_d     = 1'b1;
            out_vld_d   = 1'b1;
            out_d       = '{part: part, reg_addr: AddrFnumLo + AddrW'(chan),
                            reg_data: fnum_lo(pc), last: 1'b0};
            pend_vld_d  = 1'b1;
            pend_d      = '{part: part, reg_addr: AddrKeyBlk + AddrW'(chan),
                            reg_data: DataW'(koff_new) | KeyOnBit, last: 1'b0};
          end else if (hit_off || hit_all) begin
            head_o.note = '0;
            if (pend_vld_q) begin
              out_vld_d = 1'b1;
              out_d     = pend_q;
            end
            pend_vld_d = 1'b1;
            pend_d     = '{part: part, reg_addr: AddrKeyBlk + AddrW'(chan),
                           reg_data: DataW'(head_i.koff), last: 1'b0};
          end
          if (idx_q == IdxW'(NumVoices - 1)) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_vld_d  = 1'b1;
          out_d      = pend_q;
          out_d.last = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      found_q    <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      found_q    <= found_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    note_q <= note_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/fm_voice_allocator_unit.sv
// Top level of the FM voice allocator: configuration register, ring of slot
// cells and scan sequencer. Depends on fm_va_pkg, fm_va_cell and fm_va_ctrl.
//
//   Channel  Direction  Handshake                    Payload
//   in       input      in_valid_i / in_stall_o      in_data_i   (operation, note)
//   out      output     out_valid_o / out_stall_i    out_data_o  (part, reg_addr,
//                                                                  reg_data, last)
//   cfg      input      cfg_we_i                     cfg_wdata_i (max_voices)
//
// One event is taken per scan. After the transfer in, the sequencer walks the
// ring of NumVoices slot cells one slot per cycle while the output is free,
// then hands over the final write from the flush state. A stall on the output
// pauses the scan, since every step may load the output register.
// Reset clears every slot to free with a zero key-off value and sets the voice
// count to 18; the slot state sits in flip-flops, so there is no clearing pass.
`default_nettype none

module fm_voice_allocator_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [fm_va_pkg::CfgW-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire fm_va_pkg::in_t             in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output fm_va_pkg::out_t                 out_data_o
);
  import fm_va_pkg::*;

  logic [CfgW-1:0] max_voices_q;
  slot_t           ring [NumVoices];
  slot_t           head_new;
  logic            shift;

  // Voice count register. Values above the slot count are clamped in the
  // sequencer; the raw value is kept as written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_voices_q <= MaxVoicesRst;
    end else if (cfg_we_i) begin
      max_voices_q <= cfg_wdata_i;
    end
  end

  // The cells form a ring. Each step moves every slot one cell toward cell
  // zero, and the sequencer feeds the rewritten head slot back in at the far
  // end. After a full scan every slot is back in its own cell, so cell zero
  // always shows slot number idx during step idx.
  for (genvar k = 0; k < NumVoices; k++) begin : g_cell
    slot_t from_next;
    if (k == NumVoices - 1) begin : g_tail
      assign from_next = head_new;
    end else begin : g_body
      assign from_next = ring[k+1];
    end
    fm_va_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .slot_i (from_next),
      .slot_o (ring[k])
    );
  end

  // The sequencer holds back one write at a time so that the last write of an
  // event is known when the scan ends, and marks it with last.
  fm_va_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_voices_i(max_voices_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .head_i      (ring[0]),
    .head_o      (head_new),
    .shift_o     (shift)
  );

endmodule

`default_nettype wire

FILE: rtl/fm_va_checker.sv
// Port level checks for the FM voice allocator and the bind that attaches them.
// Depends on fm_va_pkg and fm_voice_allocator_unit.
`default_nettype none

module fm_va_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire fm_va_pkg::out_t            out_data_o
);
  import fm_va_pkg::*;

  // A stalled output transfer stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // Once an event is taken the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after an accepted event");

  // While the block is ready for a new event, only the final write of the
  // previous event can still be waiting.
  a_idle_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && out_valid_o |-> out_data_o.last)
    else $error("non-final write pending while ready for a new event");

  // Writes go to channel registers 0 to 8 of the A0 or B0 groups only.
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.reg_addr[7:5] == 3'b101) &&
                    (out_data_o.reg_addr[3:0] <= 4'd8))
    else $error("register address out of range");

  // A frequency low byte write is always followed by its key-on write.
  a_lo_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.reg_addr[7:4] == 4'hA) |-> !out_data_o.last)
    else $error("frequency low byte marked as final write");

endmodule

bind fm_voice_allocator_unit fm_va_checker u_fm_va_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

`default_nettype wire
